@@ rtl/prwrd_pkg.sv @@
// prwrd_pkg: shared widths, operation and action codes, register indexes,
// the rule entry layout and the controller/datapath command and status structs.
// Depends on nothing; every other file of the detector but prwrd_ram imports it.
`default_nettype none

package prwrd_pkg;

   // field widths
   localparam int OP_W     = 2;
   localparam int RULE_W   = 10;
   localparam int BCNT_W   = 16;
   localparam int PCNT_W   = 8;
   localparam int TIME_W   = 32;
   localparam int LIMIT_W  = 40;
   localparam int ACT_W    = 2;
   localparam int COUNT_W  = 11;
   localparam int BYTES_W  = 48;
   localparam int PKTS_W   = 32;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int WIN_W      = 16;
   localparam int DELAY_W    = 20;
   localparam int THR_W      = 16;
   localparam int THR_FRAC   = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 2'd2;

   localparam logic [WIN_W-1:0]   WIN_RESET    = 16'd1;
   localparam logic [DELAY_W-1:0] DELAY_RESET  = 20'd60;
   localparam logic [THR_W-1:0]   THRESH_RESET = 16'd819;

   // operation codes
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
   localparam logic [OP_W-1:0] OP_EVAL   = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   // action codes
   localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_NEW  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DEL  = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // rate divider: bytes / window, a few quotient bits per cycle
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_STEPS      = BYTES_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   // rate scale: rate * 800 built from shifts
   localparam int LHS_W  = BYTES_W + 10;
   localparam int PROD_W = LIMIT_W + THR_W;

   typedef struct packed {
      logic [LIMIT_W-1:0] limit;
      logic [BYTES_W-1:0] bytes;
      logic [PKTS_W-1:0]  pkts;
      logic [TIME_W-1:0]  wstart;
      logic [TIME_W-1:0]  last;
      logic [TIME_W-1:0]  rep;
      logic               active;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic capture;
      logic div_step;
      logic compare;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_eval;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/prwrd_if.sv @@
// prwrd_req_if / prwrd_rsp_if: valid/ready channels of the detector
// carrying one request or one response transaction. Depends on prwrd_pkg.
`default_nettype none

interface prwrd_req_if;
   import prwrd_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [RULE_W-1:0]   rule_index;
   logic [BCNT_W-1:0]   byte_count;
   logic [PCNT_W-1:0]   packet_count;
   logic [TIME_W-1:0]   now_seconds;
   logic [LIMIT_W-1:0]  limit_value;

   modport source (output valid, op, rule_index, byte_count, packet_count,
                   now_seconds, limit_value, input ready);
   modport sink   (input valid, op, rule_index, byte_count, packet_count,
                   now_seconds, limit_value, output ready);
endinterface

interface prwrd_rsp_if;
   import prwrd_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACT_W-1:0]    action;
   logic [RULE_W-1:0]   rule_out;
   logic [COUNT_W-1:0]  active_count;
   logic [BYTES_W-1:0]  window_bytes;
   logic [PKTS_W-1:0]   window_packets;

   modport source (output valid, action, rule_out, active_count, window_bytes,
                   window_packets, input ready);
   modport sink   (input valid, action, rule_out, active_count, window_bytes,
                   window_packets, output ready);
endinterface

`default_nettype wire

@@ rtl/prwrd_ram.sv @@
// prwrd_ram: generic single write port, single read port RAM with
// registered read data. No dependencies.
`default_nettype none

module prwrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/prwrd_ctrl.sv @@
// prwrd_ctrl: sequencer of the detector; clearing pass, fetch, divider
// iterations, compare and commit, plus the channel valid/ready flags.
// Depends on prwrd_pkg.
`default_nettype none

module prwrd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output prwrd_pkg::cmd_type cmd,
   input  prwrd_pkg::sts_type sts
);
   import prwrd_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_FETCH  = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_CMP    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.capture = 1'b1;
            div_cnt_in  = '0;
            state_in    = sts.is_eval ? S_DIV : S_FINISH;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_CMP;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/prwrd_dpath.sv @@
// prwrd_dpath: configuration registers, rule table RAM, rate divider,
// limit compare, entry update and response registers.
// Depends on prwrd_pkg and prwrd_ram.
`default_nettype none

module prwrd_dpath #(
   parameter int RULES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  prwrd_pkg::cmd_type                  cmd,
   output prwrd_pkg::sts_type                  sts,
   input  logic                                csr_we,
   input  logic [prwrd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [prwrd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [prwrd_pkg::OP_W-1:0]          req_op,
   input  logic [prwrd_pkg::RULE_W-1:0]        req_rule_index,
   input  logic [prwrd_pkg::BCNT_W-1:0]        req_byte_count,
   input  logic [prwrd_pkg::PCNT_W-1:0]        req_packet_count,
   input  logic [prwrd_pkg::TIME_W-1:0]        req_now_seconds,
   input  logic [prwrd_pkg::LIMIT_W-1:0]       req_limit_value,
   output logic [prwrd_pkg::ACT_W-1:0]         rsp_action,
   output logic [prwrd_pkg::RULE_W-1:0]        rsp_rule_out,
   output logic [prwrd_pkg::COUNT_W-1:0]       rsp_active_count,
   output logic [prwrd_pkg::BYTES_W-1:0]       rsp_window_bytes,
   output logic [prwrd_pkg::PKTS_W-1:0]        rsp_window_packets
);
   import prwrd_pkg::*;

   localparam int AW = (RULES > 1) ? $clog2(RULES) : 1;
   localparam int CW = AW + 1;

   // configuration registers
   logic [WIN_W-1:0]   win_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [WIN_W-1:0]   win_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= WIN_RESET;
         delay_ff <= DELAY_RESET;
         thr_ff   <= THRESH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW: win_ff   <= csr_wdata[WIN_W-1:0];
            CSR_DELAY:  delay_ff <= csr_wdata[DELAY_W-1:0];
            CSR_THRESH: thr_ff   <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // a zero window counts as one second
   assign win_eff = (win_ff == '0) ? WIN_W'(1) : win_ff;

   // clearing pass counter
   logic [CW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign sts.clear_last = (clr_ff == CW'(RULES - 1));

   // transaction capture
   logic [OP_W-1:0]    op_ff;
   logic [RULE_W-1:0]  idx_ff;
   logic [BCNT_W-1:0]  bc_ff;
   logic [PCNT_W-1:0]  pc_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [LIMIT_W-1:0] lim_ff;
   logic               in_range_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_op;
         idx_ff      <= req_rule_index;
         bc_ff       <= req_byte_count;
         pc_ff       <= req_packet_count;
         now_ff      <= req_now_seconds;
         lim_ff      <= req_limit_value;
         in_range_ff <= ({22'd0, req_rule_index} < 32'(RULES));
      end
   end

   assign sts.is_eval = in_range_ff && (op_ff == OP_EVAL);

   // rule table
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type          ram_ent;
   entry_type          nxt;
   logic               wr_need;

   assign ram_we    = cmd.clear_step || (cmd.commit && wr_need);
   assign ram_waddr = cmd.clear_step ? clr_ff[AW-1:0] : AW'(idx_ff);
   assign ram_wdata = cmd.clear_step ? '0 : nxt;

   prwrd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RULES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (AW'(req_rule_index)),
      .rd_data (ram_rdata)
   );

   assign ram_ent = entry_type'(ram_rdata);

   // entry register and radix-16 restoring divider
   entry_type          ent_ff;
   logic [BYTES_W-1:0] quo_ff, quo_in;
   logic [WIN_W-1:0]   rem_ff, rem_in;

   always_comb begin
      logic [WIN_W:0]     trial;
      logic [WIN_W-1:0]   r;
      logic [BYTES_W-1:0] q;
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         trial = {r, q[BYTES_W-1]};
         q     = {q[BYTES_W-2:0], 1'b0};
         if (trial >= {1'b0, win_eff}) begin
            trial = trial - {1'b0, win_eff};
            q[0]  = 1'b1;
         end
         r = trial[WIN_W-1:0];
      end
      rem_in = r;
      quo_in = q;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ent_ff <= ram_ent;
         quo_ff <= ram_ent.bytes;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // scaled limit, settles while the divider runs
   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= ent_ff.limit * thr_ff;
   end

   // over-limit and release decisions
   logic [LHS_W-1:0] lhs;
   logic [LHS_W-1:0] rhs;
   logic             over_ff;
   logic             rel_ff;

   assign lhs = (LHS_W'(quo_ff) << 9) + (LHS_W'(quo_ff) << 8) + (LHS_W'(quo_ff) << 5);
   assign rhs = LHS_W'(prod_ff[PROD_W-1:THR_FRAC]);

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         over_ff <= (lhs > rhs);
         rel_ff  <= ((33'(ent_ff.rep) + 33'(delay_ff)) < 33'(ent_ff.last)) &&
                    (33'(ent_ff.last) >= (33'(ent_ff.wstart) + 33'(win_eff)));
      end
   end

   // entry update and response values
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [ACT_W-1:0]   act;
   logic [BYTES_W:0]   bsum;
   logic [PKTS_W:0]    psum;
   logic               wover;

   assign bsum  = (BYTES_W+1)'(ent_ff.bytes) + (BYTES_W+1)'(bc_ff);
   assign psum  = (PKTS_W+1)'(ent_ff.pkts) + (PKTS_W+1)'(pc_ff);
   assign wover = 33'(now_ff) >= (33'(ent_ff.wstart) + 33'(win_eff));

   always_comb begin
      nxt     = ent_ff;
      act     = ACT_NONE;
      cnt_in  = cnt_ff;
      wr_need = 1'b0;
      if (in_range_ff) begin
         case (op_ff)
            OP_UPDATE: begin
               wr_need    = 1'b1;
               nxt.last   = now_ff;
               nxt.bytes  = bsum[BYTES_W] ? '1 : bsum[BYTES_W-1:0];
               nxt.pkts   = psum[PKTS_W] ? '1 : psum[PKTS_W-1:0];
               if (wover) begin
                  nxt.wstart = now_ff;
                  nxt.bytes  = '0;
                  nxt.pkts   = '0;
               end
            end
            OP_EVAL: begin
               wr_need = 1'b1;
               if (over_ff) begin
                  if (!ent_ff.active) begin
                     nxt.active = 1'b1;
                     act        = ACT_NEW;
                     if (cnt_ff != COUNT_MAX) begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  nxt.rep = ent_ff.last;
               end else if (ent_ff.active && rel_ff) begin
                  nxt.active = 1'b0;
                  nxt.rep    = '0;
                  act        = ACT_DEL;
                  if (cnt_ff != '0) begin
                     cnt_in = cnt_ff - 1'b1;
                  end
               end
            end
            OP_LOAD: begin
               wr_need   = 1'b1;
               nxt       = '0;
               nxt.limit = lim_ff;
               if (ent_ff.active && (cnt_ff != '0)) begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // active count and response registers
   logic [ACT_W-1:0]   act_ff;
   logic [RULE_W-1:0]  rule_out_ff;
   logic [COUNT_W-1:0] cnt_out_ff;
   logic [BYTES_W-1:0] bytes_out_ff;
   logic [PKTS_W-1:0]  pkts_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.commit) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         act_ff       <= act;
         rule_out_ff  <= idx_ff;
         cnt_out_ff   <= cnt_in;
         bytes_out_ff <= in_range_ff ? nxt.bytes : '0;
         pkts_out_ff  <= in_range_ff ? nxt.pkts : '0;
      end
   end

   assign rsp_action         = act_ff;
   assign rsp_rule_out       = rule_out_ff;
   assign rsp_active_count   = cnt_out_ff;
   assign rsp_window_bytes   = bytes_out_ff;
   assign rsp_window_packets = pkts_out_ff;

endmodule

`default_nettype wire

@@ rtl/per_rule_window_rate_detector.sv @@
// per_rule_window_rate_detector: top level of the per-rule windowed rate
// detector. Depends on prwrd_pkg, prwrd_if, prwrd_ctrl and prwrd_dpath.
//
//   channel   direction  handshake     carries
//   req_chan  in         valid/ready   op, rule_index, counts, time, limit
//   rsp_chan  out        valid/ready   action, rule, active count, counters
//   csr_*     in         write enable  window, remove delay, threshold
//
// An evaluation passes through the accept cycle (table read), fetch, 12
// radix-16 divider iterations, compare and commit, which registers the
// response. Updates, loads, no-ops and out-of-range evaluations go
// through table read, fetch and commit only.
// After reset a clearing pass zeroes all RULES entries of the rule table,
// during which no request is taken; csr writes are taken at any time.
// One transaction is in work at a time; a held response stalls only commit.
`default_nettype none

module per_rule_window_rate_detector #(
   parameter int RULES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   prwrd_req_if.sink                        req_chan,
   prwrd_rsp_if.source                      rsp_chan,
   input  logic                             csr_we,
   input  logic [prwrd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [prwrd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import prwrd_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;
   logic    rsp_valid;

   prwrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   prwrd_dpath #(
      .RULES (RULES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_op             (req_chan.op),
      .req_rule_index     (req_chan.rule_index),
      .req_byte_count     (req_chan.byte_count),
      .req_packet_count   (req_chan.packet_count),
      .req_now_seconds    (req_chan.now_seconds),
      .req_limit_value    (req_chan.limit_value),
      .rsp_action         (rsp_chan.action),
      .rsp_rule_out       (rsp_chan.rule_out),
      .rsp_active_count   (rsp_chan.active_count),
      .rsp_window_bytes   (rsp_chan.window_bytes),
      .rsp_window_packets (rsp_chan.window_packets)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // a response never appears right after the transaction that causes it
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response raised one cycle after acceptance");

   // a newly active rule is counted
   a_new_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_chan.action == ACT_NEW)) |-> (rsp_chan.active_count != '0))
      else $error("new rule reported with zero active count");

   // the active count never exceeds the number of rules
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({21'd0, rsp_chan.active_count} <= 32'(RULES)))
      else $error("active count above table size");

   // no request is taken while a command sequence is running
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture || cmd.div_step || cmd.compare) |-> !req_ready)
      else $error("request ready while a transaction is in work");

endmodule

`default_nettype wire

@@ tb/tb_per_rule_window_rate_detector.sv @@
// tb_per_rule_window_rate_detector: self-checking testbench for the per-rule
// windowed rate detector; predicts every response and compares field by field.
// Depends on prwrd_pkg, prwrd_if and per_rule_window_rate_detector.
`timescale 1ns / 100ps

module tb_per_rule_window_rate_detector;
   import prwrd_pkg::*;

   localparam int RULE_COUNT   = 1024;
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 150;
   localparam int SETTLE       = 20;

   localparam logic [BYTES_W-1:0] BYTES_CAP = '1;
   localparam logic [PKTS_W-1:0]  PKTS_CAP  = '1;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [RULE_W-1:0]  rule_idx;
      logic [BCNT_W-1:0]  nbytes;
      logic [PCNT_W-1:0]  npkts;
      logic [TIME_W-1:0]  now;
      logic [LIMIT_W-1:0] limit;
   } rate_req_type;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [RULE_W-1:0]  rule_idx;
      logic [COUNT_W-1:0] count;
      logic [BYTES_W-1:0] nbytes;
      logic [PKTS_W-1:0]  npkts;
   } rate_rsp_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   prwrd_req_if req_chan ();
   prwrd_rsp_if rsp_chan ();

   per_rule_window_rate_detector #(.RULES(RULE_COUNT)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the rule table and the global registers
   logic [LIMIT_W-1:0] lim_tbl    [RULE_COUNT];
   logic [BYTES_W-1:0] byte_tbl   [RULE_COUNT];
   logic [PKTS_W-1:0]  pkt_tbl    [RULE_COUNT];
   logic [TIME_W-1:0]  wstart_tbl [RULE_COUNT];
   logic [TIME_W-1:0]  seen_tbl   [RULE_COUNT];
   logic [TIME_W-1:0]  rep_tbl    [RULE_COUNT];
   logic               act_tbl    [RULE_COUNT];
   logic [COUNT_W-1:0] active_total;
   logic [WIN_W-1:0]   win_cfg;
   logic [DELAY_W-1:0] delay_cfg;
   logic [THR_W-1:0]   thr_cfg;

   rate_rsp_type pending_verdicts [$];

   // stimulus control shared by the sender, receiver and tests
   bit          req_idle_on;
   bit          rsp_idle_on;
   int          rsp_hold_cycles;
   logic [RULE_W-1:0] hot_rules [8];
   logic [TIME_W-1:0] sim_now;

   int error_count;
   int items_sent;
   int rsp_checked;
   int new_seen;
   int del_seen;
   int settings_used;
   int idle_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // expected response for one transaction; updates the predictor state
   function automatic rate_rsp_type predict_verdict(input rate_req_type t);
      rate_rsp_type v;
      logic [63:0] win;
      logic [63:0] sum;
      logic [63:0] rate;
      logic [63:0] lhs;
      logic [63:0] rhs;
      int          i;
      win = (win_cfg == '0) ? 64'd1 : 64'(win_cfg);
      i = int'(t.rule_idx);
      v.action = ACT_NONE;
      case (t.op)
         OP_UPDATE: begin
            seen_tbl[i] = t.now;
            sum = 64'(byte_tbl[i]) + 64'(t.nbytes);
            byte_tbl[i] = (sum > 64'(BYTES_CAP)) ? BYTES_CAP : sum[BYTES_W-1:0];
            sum = 64'(pkt_tbl[i]) + 64'(t.npkts);
            pkt_tbl[i] = (sum > 64'(PKTS_CAP)) ? PKTS_CAP : sum[PKTS_W-1:0];
            // window ran out: restart at now, this packet is dropped from the counts
            if (64'(t.now) >= 64'(wstart_tbl[i]) + win) begin
               wstart_tbl[i] = t.now;
               byte_tbl[i] = '0;
               pkt_tbl[i] = '0;
            end
         end
         OP_EVAL: begin
            rate = 64'(byte_tbl[i]) / win;
            lhs = rate * 64'd800;
            rhs = (64'(lim_tbl[i]) * 64'(thr_cfg)) >> THR_FRAC;
            if (lhs > rhs) begin
               if (!act_tbl[i]) begin
                  act_tbl[i] = 1'b1;
                  if (active_total != COUNT_MAX) active_total = active_total + 1'b1;
                  v.action = ACT_NEW;
               end
               rep_tbl[i] = seen_tbl[i];
            end else if (act_tbl[i] &&
                         64'(rep_tbl[i]) + 64'(delay_cfg) < 64'(seen_tbl[i]) &&
                         64'(seen_tbl[i]) >= 64'(wstart_tbl[i]) + win) begin
               act_tbl[i] = 1'b0;
               rep_tbl[i] = '0;
               if (active_total != '0) active_total = active_total - 1'b1;
               v.action = ACT_DEL;
            end
         end
         OP_LOAD: begin
            // an active rule is dropped silently
            if (act_tbl[i] && active_total != '0) active_total = active_total - 1'b1;
            lim_tbl[i] = t.limit;
            byte_tbl[i] = '0;
            pkt_tbl[i] = '0;
            wstart_tbl[i] = '0;
            seen_tbl[i] = '0;
            rep_tbl[i] = '0;
            act_tbl[i] = 1'b0;
         end
         default: ;
      endcase
      v.rule_idx = t.rule_idx;
      v.count = active_total;
      v.nbytes = byte_tbl[i];
      v.npkts = pkt_tbl[i];
      return v;
   endfunction

   function automatic rate_req_type mk_req(input logic [OP_W-1:0] op,
                                           input logic [RULE_W-1:0] rule_idx,
                                           input logic [BCNT_W-1:0] nbytes,
                                           input logic [PCNT_W-1:0] npkts,
                                           input logic [TIME_W-1:0] now,
                                           input logic [LIMIT_W-1:0] limit);
      rate_req_type t;
      t.op = op;
      t.rule_idx = rule_idx;
      t.nbytes = nbytes;
      t.npkts = npkts;
      t.now = now;
      t.limit = limit;
      return t;
   endfunction

   // mostly traffic on a few hot rules with a rising clock, some noise
   function automatic rate_req_type draw_traffic_item();
      rate_req_type t;
      int unsigned  sel;
      t.nbytes = BCNT_W'($urandom);
      t.npkts = PCNT_W'($urandom);
      t.now = $urandom;
      t.limit = LIMIT_W'({$urandom, $urandom});
      if ($urandom_range(0, 99) < 85) t.rule_idx = hot_rules[$urandom_range(0, 7)];
      else t.rule_idx = RULE_W'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         t.op = OP_UPDATE;
         if ($urandom_range(0, 1) == 0) t.nbytes = BCNT_W'($urandom_range(0, 2000));
         if ($urandom_range(0, 99) >= 3) begin
            sim_now = sim_now + $urandom_range(0, 3);
            t.now = sim_now;
         end
      end else if (sel < 85) begin
         t.op = OP_EVAL;
      end else if (sel < 93) begin
         t.op = OP_LOAD;
         case ($urandom_range(0, 3))
            0: t.limit = LIMIT_W'($urandom_range(0, 1000));
            1, 2: t.limit = LIMIT_W'($urandom_range(0, 1 << 24));
            default: ;
         endcase
      end else begin
         t.op = OP_NOP;
      end
      return t;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // offer one transaction, predict its response once it is taken
   task automatic send_request(input rate_req_type t);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.op           <= t.op;
      req_chan.rule_index   <= t.rule_idx;
      req_chan.byte_count   <= t.nbytes;
      req_chan.packet_count <= t.npkts;
      req_chan.now_seconds  <= t.now;
      req_chan.limit_value  <= t.limit;
      do @(posedge clock); while (!req_chan.ready);
      pending_verdicts.push_back(predict_verdict(t));
      items_sent++;
   endtask

   // drop valid and let every outstanding response drain
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_WINDOW: win_cfg = val[WIN_W-1:0];
         CSR_DELAY:  delay_cfg = val[DELAY_W-1:0];
         CSR_THRESH: thr_cfg = val[THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [WIN_W-1:0] win, input logic [DELAY_W-1:0] dly,
                             input logic [THR_W-1:0] thr);
      wait_idle();
      write_csr(CSR_WINDOW, CSR_DATA_W'(win));
      write_csr(CSR_DELAY, dly);
      write_csr(CSR_THRESH, CSR_DATA_W'(thr));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // opcodes at the field extremes, silent drop of an active rule on load
   task automatic test_basic_ops();
      send_request(mk_req(OP_LOAD, 10'd0, 16'd0, 8'd0, 32'd0, 40'd0));
      send_request(mk_req(OP_UPDATE, 10'd0, 16'hFFFF, 8'hFF, 32'd0, 40'd0));
      send_request(mk_req(OP_EVAL, 10'd0, 16'd0, 8'd0, 32'd0, 40'd0));
      send_request(mk_req(OP_EVAL, 10'd0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, '1));
      send_request(mk_req(OP_LOAD, 10'd0, 16'd0, 8'd0, 32'd0, '1));
      send_request(mk_req(OP_NOP, 10'd0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, '1));
      wait_idle();
   endtask

   // time sums at the top of the range, activity of a rule reported at time zero
   task automatic test_time_edges();
      send_request(mk_req(OP_UPDATE, 10'd1023, 16'd1, 8'd1, 32'hFFFF_FFFF, 40'd0));
      send_request(mk_req(OP_UPDATE, 10'd1023, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 40'd0));
      send_request(mk_req(OP_EVAL, 10'd1023, 16'd0, 8'd0, 32'd0, 40'd0));
      send_request(mk_req(OP_UPDATE, 10'd2, 16'd100, 8'd1, 32'd0, 40'd0));
      send_request(mk_req(OP_EVAL, 10'd2, 16'd0, 8'd0, 32'd0, 40'd0));
      send_request(mk_req(OP_EVAL, 10'd2, 16'd0, 8'd0, 32'd0, 40'd0));
      send_request(mk_req(OP_NOP, 10'd5, 16'd0, 8'd0, 32'd0, 40'd0));
      wait_idle();
   endtask

   // over limit, window restart, then a shorter window lets the rule go
   task automatic test_release_path();
      set_config(16'd100, 20'd0, THRESH_RESET);
      send_request(mk_req(OP_LOAD, 10'd3, 16'd0, 8'd0, 32'd0, 40'd1000000));
      send_request(mk_req(OP_UPDATE, 10'd3, 16'd0, 8'd0, 32'd200, 40'd0));
      send_request(mk_req(OP_UPDATE, 10'd3, 16'hFFFF, 8'd1, 32'd201, 40'd0));
      send_request(mk_req(OP_UPDATE, 10'd3, 16'hFFFF, 8'd1, 32'd202, 40'd0));
      send_request(mk_req(OP_EVAL, 10'd3, 16'd0, 8'd0, 32'd0, 40'd0));
      send_request(mk_req(OP_UPDATE, 10'd3, 16'd5, 8'd1, 32'd300, 40'd0));
      send_request(mk_req(OP_UPDATE, 10'd3, 16'd5, 8'd1, 32'd305, 40'd0));
      send_request(mk_req(OP_EVAL, 10'd3, 16'd0, 8'd0, 32'd0, 40'd0));
      // zero window acts as one second
      set_config(16'd0, 20'd0, THRESH_RESET);
      send_request(mk_req(OP_EVAL, 10'd3, 16'd0, 8'd0, 32'd0, 40'd0));
      send_request(mk_req(OP_EVAL, 10'd2, 16'd0, 8'd0, 32'd0, 40'd0));
      wait_idle();
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (12) send_request(draw_traffic_item());
      wait_idle();
   endtask

   // phases of random traffic, each under its own register setting
   task automatic test_random_traffic();
      logic [WIN_W-1:0]   win;
      logic [DELAY_W-1:0] dly;
      logic [THR_W-1:0]   thr;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               win = '1;
               dly = '1;
               thr = '1;
            end
            1: begin
               win = '0;
               dly = '0;
               thr = '0;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: win = 16'd1;
                  1: win = WIN_W'($urandom_range(2, 8));
                  2: win = WIN_W'($urandom_range(9, 300));
                  default: win = WIN_W'($urandom_range(0, 65535));
               endcase
               dly = ($urandom_range(0, 3) == 3) ? DELAY_W'($urandom_range(0, 1048575))
                                                 : DELAY_W'($urandom_range(0, 20));
               case ($urandom_range(0, 2))
                  0: thr = THRESH_RESET;
                  1: thr = THR_W'($urandom_range(0, 2048));
                  default: thr = THR_W'($urandom_range(0, 65535));
               endcase
            end
         endcase
         set_config(win, dly, thr);
         req_idle_on = (p % 2 == 0);
         rsp_idle_on = (p % 4 < 2);
         hot_rules[$urandom_range(2, 7)] = RULE_W'($urandom);
         repeat (PHASE_ITEMS) send_request(draw_traffic_item());
      end
      wait_idle();
   endtask

   // result receiver: random or long hold-off per transaction
   initial begin : rsp_side
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            n = rsp_idle_on ? $urandom_range(0, 19) : 0;
         end
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin : check_rsp
      rate_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_verdicts.size() == 0) begin
            error_count++;
            $display("%0t: response with none expected, expected nothing, actual %0h %0h",
                     $time, rsp_chan.action, rsp_chan.rule_out);
         end else begin
            want = pending_verdicts.pop_front();
            check_field("action", 64'(want.action), 64'(rsp_chan.action));
            check_field("rule_out", 64'(want.rule_idx), 64'(rsp_chan.rule_out));
            check_field("active_count", 64'(want.count), 64'(rsp_chan.active_count));
            check_field("window_bytes", 64'(want.nbytes), 64'(rsp_chan.window_bytes));
            check_field("window_packets", 64'(want.npkts), 64'(rsp_chan.window_packets));
            rsp_checked++;
            if (want.action == ACT_NEW) new_seen++;
            if (want.action == ACT_DEL) del_seen++;
         end
      end
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= '0;
      csr_wdata             <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.op           <= OP_NOP;
      req_chan.rule_index   <= '0;
      req_chan.byte_count   <= '0;
      req_chan.packet_count <= '0;
      req_chan.now_seconds  <= '0;
      req_chan.limit_value  <= '0;
      rsp_chan.ready        <= 1'b0;
      error_count           = 0;
      items_sent            = 0;
      rsp_checked           = 0;
      new_seen              = 0;
      del_seen              = 0;
      settings_used         = 1;
      rsp_hold_cycles       = 0;
      req_idle_on           = 1'b1;
      rsp_idle_on           = 1'b1;
      sim_now               = 32'd1000;
      win_cfg               = WIN_RESET;
      delay_cfg             = DELAY_RESET;
      thr_cfg               = THRESH_RESET;
      active_total          = '0;
      for (int i = 0; i < RULE_COUNT; i++) begin
         lim_tbl[i] = '0;
         byte_tbl[i] = '0;
         pkt_tbl[i] = '0;
         wstart_tbl[i] = '0;
         seen_tbl[i] = '0;
         rep_tbl[i] = '0;
         act_tbl[i] = 1'b0;
      end
      hot_rules[0] = 10'd0;
      hot_rules[1] = 10'd1023;
      for (int i = 2; i < 8; i++) hot_rules[i] = RULE_W'($urandom);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_time_edges();
      test_release_path();
      test_backpressure();
      test_random_traffic();
      wait_idle();

      $display("covered %0d requests under %0d register settings, %0d responses checked",
               items_sent, settings_used, rsp_checked);
      $display("rules activated %0d times and released %0d times, %0d mismatches",
               new_seen, del_seen, error_count);
      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
